// ===== design/triangle_midpoint_subdivider_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider: assertion macros
// Shared concurrent assertion forms, clocked and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_MACROS_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider package
// Field widths, command codes, job and result records, normalizer handshake.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int IDX_W   = 12;
    localparam int COORD_W = 16;
    localparam int SUM_W   = 17;
    localparam int FRAC_W  = 14;
    localparam int KEY_W   = 2 * IDX_W;
    localparam int HASH_W  = 17;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TRI   = 2'd2;

    localparam logic KIND_MID = 1'b0;
    localparam logic KIND_TRI = 1'b1;

    // Low bits of the two hash multipliers; only the low slot bits matter.
    localparam logic [HASH_W-1:0] HASH_K1 = 17'h179B1;
    localparam logic [HASH_W-1:0] HASH_K2 = 17'h09E37;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_TRI
    } t_op;

    typedef struct packed {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [HASH_W-1:0] home;
    } t_edge;

    typedef struct packed {
        t_op                       op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          a;
        logic [IDX_W-1:0]          b;
        logic [IDX_W-1:0]          c;
        t_edge [2:0]               edges;
    } t_job;

    typedef struct packed {
        logic                      valid;
        logic [KEY_W-1:0]          key;
        logic [IDX_W-1:0]          idx;
    } t_slot;

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          new_index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          tri_a;
        logic [IDX_W-1:0]          tri_b;
        logic [IDX_W-1:0]          tri_c;
        logic                      overflow;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_norm_req;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_norm_rsp;

    function automatic t_result mk_mid(logic [IDX_W-1:0] idx, logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y,
                                       logic signed [COORD_W-1:0] z);
        t_result r;
        r           = '0;
        r.kind      = KIND_MID;
        r.new_index = idx;
        r.x         = x;
        r.y         = y;
        r.z         = z;
        return r;
    endfunction

    function automatic t_result mk_tri(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                       logic [IDX_W-1:0] c, logic last);
        t_result r;
        r       = '0;
        r.kind  = KIND_TRI;
        r.tri_a = a;
        r.tri_b = b;
        r.tri_c = c;
        r.last  = last;
        return r;
    endfunction

    function automatic t_result mk_ovf();
        t_result r;
        r          = '0;
        r.kind     = KIND_MID;
        r.overflow = 1'b1;
        r.last     = 1'b1;
        return r;
    endfunction

endpackage

// ===== design/tms_front.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider: front end
// Accepts input beats, decodes the command, sorts edge pairs, hashes them.
// ----------------------------------------------------------------------------
module tms_front #(
    parameter int EDGE_SLOTS = 8192
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic signed [tms_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tms_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tms_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tms_pkg::IDX_W-1:0]          i_vertex_a,
    input  logic [tms_pkg::IDX_W-1:0]          i_vertex_b,
    input  logic [tms_pkg::IDX_W-1:0]          i_vertex_c,
    input  logic                               i_hold,
    input  logic                               i_full,
    output logic                               o_push,
    output tms_pkg::t_job                      o_job
);
    import tms_pkg::*;

    localparam int SW = $clog2(EDGE_SLOTS);

    logic                      r_v;
    t_op                       r_op;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic [IDX_W-1:0]          r_a, r_b, r_c;
    logic [IDX_W-1:0]          r_lo [3];
    logic [IDX_W-1:0]          r_hi [3];
    logic [HASH_W-1:0]         r_p1 [3];
    logic [HASH_W-1:0]         r_p2 [3];

    logic             accept, keep;
    t_op              op;
    logic [IDX_W-1:0] eu [3];
    logic [IDX_W-1:0] ev [3];
    logic [IDX_W-1:0] lo [3];
    logic [IDX_W-1:0] hi [3];
    logic [HASH_W-1:0] h [3];
    logic [SW-1:0]    hs [3];

    assign o_push  = r_v && !i_full;
    assign o_stall = (r_v && i_full) || i_hold;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        op   = OP_CLEAR;
        keep = 1'b0;
        unique case (i_cmd)
            CMD_CLEAR: begin
                op   = OP_CLEAR;
                keep = accept;
            end
            CMD_LOAD: begin
                op   = OP_LOAD;
                keep = accept;
            end
            CMD_TRI: begin
                op   = OP_TRI;
                keep = accept;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Edge order ab, ac, bc; key is the sorted pair.
    always_comb begin
        eu[0] = i_vertex_a; ev[0] = i_vertex_b;
        eu[1] = i_vertex_a; ev[1] = i_vertex_c;
        eu[2] = i_vertex_b; ev[2] = i_vertex_c;
        for (int e = 0; e < 3; e++) begin
            lo[e] = (eu[e] < ev[e]) ? eu[e] : ev[e];
            hi[e] = (eu[e] < ev[e]) ? ev[e] : eu[e];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!r_v || o_push) begin
            r_v <= keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= op;
            r_x  <= i_coord_x;
            r_y  <= i_coord_y;
            r_z  <= i_coord_z;
            r_a  <= i_vertex_a;
            r_b  <= i_vertex_b;
            r_c  <= i_vertex_c;
            for (int e = 0; e < 3; e++) begin
                r_lo[e] <= lo[e];
                r_hi[e] <= hi[e];
                r_p1[e] <= HASH_W'(lo[e]) * HASH_K1;
                r_p2[e] <= HASH_W'(hi[e]) * HASH_K2;
            end
        end
    end

    // Fold the hash into the table range: one conditional subtract.
    always_comb begin
        o_job    = '0;
        o_job.op = r_op;
        o_job.x  = r_x;
        o_job.y  = r_y;
        o_job.z  = r_z;
        o_job.a  = r_a;
        o_job.b  = r_b;
        o_job.c  = r_c;
        for (int e = 0; e < 3; e++) begin
            h[e]  = r_p1[e] ^ r_p2[e];
            hs[e] = h[e][SW-1:0];
            if ((SW+1)'(hs[e]) >= (SW+1)'(EDGE_SLOTS)) begin
                hs[e] = hs[e] - SW'(EDGE_SLOTS);
            end
            o_job.edges[e].lo   = r_lo[e];
            o_job.edges[e].hi   = r_hi[e];
            o_job.edges[e].home = HASH_W'(hs[e]);
        end
    end

endmodule

// ===== design/tms_fifo.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider: job queue
// Two-entry queue of decoded jobs between front end and back end.
// ----------------------------------------------------------------------------
module tms_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tms_pkg::t_job i_job,
    input  logic          i_pop,
    output tms_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import tms_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== design/tms_norm.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider: normalizer
// Scales a 17-bit vector to unit length in Q2.14, one result bit per candidate and test step.
// ----------------------------------------------------------------------------
module tms_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tms_pkg::t_norm_req i_req,
    output tms_pkg::t_norm_rsp o_rsp
);
    import tms_pkg::*;

    localparam int SQ_W   = 2 * SUM_W;
    localparam int WIDE_W = 4 * SUM_W;
    localparam int LO_W   = FRAC_W + 1;
    localparam int BIT_W  = $clog2(LO_W);
    localparam int SH_W   = 7;
    localparam int R_SH   = 2 * FRAC_W + 2;

    typedef enum logic [5:0] {
        N_IDLE = 6'b000001,
        N_SQ   = 6'b000010,
        N_ACC  = 6'b000100,
        N_AXIS = 6'b001000,
        N_CAND = 6'b010000,
        N_TEST = 6'b100000
    } t_nstate;

    t_nstate                   r_state;
    logic signed [SUM_W-1:0]   r_v [3];
    logic [1:0]                r_ax;
    logic [SQ_W-1:0]           r_sq;
    logic [SQ_W-1:0]           r_s;
    logic [LO_W-1:0]           r_lo;
    logic [WIDE_W-1:0]         r_m2, r_m1, r_c2, r_c1;
    logic [BIT_W-1:0]          r_bit;
    logic signed [COORD_W-1:0] r_res [3];
    logic                      r_done;

    logic signed [SUM_W-1:0]   cur;
    logic [SUM_W-1:0]          mag;
    logic [SQ_W-1:0]           sq;
    logic [SH_W-1:0]           sh_m1, sh_s2, sh_s1;
    logic [WIDE_W-1:0]         c2_n, c1_n, lhs, rhs;
    logic                      fits;
    logic [LO_W-1:0]           lo_new, lo_fin;
    logic signed [COORD_W-1:0] res;

    always_comb begin
        cur    = r_v[r_ax];
        mag    = cur[SUM_W-1] ? SUM_W'(-cur) : SUM_W'(cur);
        sq     = SQ_W'(mag) * SQ_W'(mag);
        sh_m1  = SH_W'(r_bit) + SH_W'(2);
        sh_s2  = SH_W'({r_bit, 1'b0}) + SH_W'(2);
        sh_s1  = SH_W'(r_bit) + SH_W'(1);
        c2_n   = r_m2 + (r_m1 << sh_m1) + (WIDE_W'(r_s) << sh_s2);
        c1_n   = r_m1 + (WIDE_W'(r_s) << sh_s1);
        // Candidate passes when (2*lo - 1)^2 * s <= v^2 * 2^30.
        lhs    = r_c2 - (r_c1 << 1) + WIDE_W'(r_s);
        rhs    = WIDE_W'(r_sq) << R_SH;
        fits   = (lhs <= rhs);
        lo_new = r_lo | (LO_W'(1) << r_bit);
        lo_fin = fits ? lo_new : r_lo;
        res    = cur[SUM_W-1] ? -COORD_W'(lo_fin) : COORD_W'(lo_fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_req.start) begin
                        r_v[0]  <= i_req.x;
                        r_v[1]  <= i_req.y;
                        r_v[2]  <= i_req.z;
                        r_ax    <= '0;
                        r_s     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_sq    <= sq;
                    r_state <= N_ACC;
                end
                N_ACC: begin
                    r_s <= r_s + r_sq;
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_state <= N_AXIS;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= N_SQ;
                    end
                end
                N_AXIS: begin
                    if (r_s == '0) begin
                        // Zero length: the midpoint is the origin.
                        r_res[0] <= '0;
                        r_res[1] <= '0;
                        r_res[2] <= '0;
                        r_done   <= 1'b1;
                        r_state  <= N_IDLE;
                    end else begin
                        r_sq    <= sq;
                        r_lo    <= '0;
                        r_m2    <= '0;
                        r_m1    <= '0;
                        r_bit   <= BIT_W'(LO_W - 1);
                        r_state <= N_CAND;
                    end
                end
                N_CAND: begin
                    r_c2    <= c2_n;
                    r_c1    <= c1_n;
                    r_state <= N_TEST;
                end
                N_TEST: begin
                    if (fits) begin
                        r_lo <= lo_new;
                        r_m2 <= r_c2;
                        r_m1 <= r_c1;
                    end
                    if (r_bit == '0) begin
                        r_res[r_ax] <= res;
                        if (r_ax == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= N_AXIS;
                        end
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= N_CAND;
                    end
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_res[0];
    assign o_rsp.y    = r_res[1];
    assign o_rsp.z    = r_res[2];

endmodule

// ===== design/tms_back.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider: back end
// Owns the point store and edge table, runs jobs, drives the result register.
// ----------------------------------------------------------------------------
module tms_back #(
    parameter int MAX_POINTS = 4096,
    parameter int EDGE_SLOTS = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tms_pkg::t_job      i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_sweeping,
    output tms_pkg::t_norm_req o_norm_req,
    input  tms_pkg::t_norm_rsp i_norm_rsp,
    input  logic               i_stall,
    output logic               o_valid,
    output tms_pkg::t_result   o_res
);
    import tms_pkg::*;

    localparam int PW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SW   = $clog2(EDGE_SLOTS);
    localparam int PC_W = $clog2(EDGE_SLOTS + 1);
    localparam int PT_W = 3 * COORD_W;

    typedef enum logic [10:0] {
        B_SWEEP     = 11'b00000000001,
        B_IDLE      = 11'b00000000010,
        B_PROBE_RD  = 11'b00000000100,
        B_PROBE_CHK = 11'b00000001000,
        B_RD_U      = 11'b00000010000,
        B_RD_V      = 11'b00000100000,
        B_SUM       = 11'b00001000000,
        B_NORM      = 11'b00010000000,
        B_STORE     = 11'b00100000000,
        B_CHILD     = 11'b01000000000,
        B_OVF       = 11'b10000000000
    } t_bstate;

    // Point store and edge table
    logic [PT_W-1:0] m_pt [MAX_POINTS];
    logic [PT_W-1:0] r_pt_rd;
    t_slot           m_edge [EDGE_SLOTS];
    t_slot           r_edge_rd;

    t_bstate           r_state;
    t_job              r_job;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_sweep;
    logic [1:0]        r_sel;
    logic [SW-1:0]     r_slot;
    logic [PC_W-1:0]   r_probes;
    logic [IDX_W-1:0]  r_mid [3];
    logic [PT_W-1:0]   r_u_pt;
    logic [1:0]        r_child;
    logic              r_start;
    logic signed [SUM_W-1:0] r_sx, r_sy, r_sz;
    t_result           r_out;
    logic              r_out_valid;

    logic              out_free, full;
    t_edge             cur;
    logic [KEY_W-1:0]  key;
    logic              lo_in, hi_in;
    logic [PT_W-1:0]   v_pt;
    logic [IDX_W-1:0]  new_idx;
    logic              pt_we, pt_re, edge_we, edge_re;
    logic [PW-1:0]     pt_wa, pt_ra;
    logic [PT_W-1:0]   pt_wd;
    logic [SW-1:0]     edge_wa;
    t_slot             edge_wd;

    function automatic logic [SW-1:0] home_of(t_edge e);
        return e.home[SW-1:0];
    endfunction

    assign out_free   = !r_out_valid || !i_stall;
    assign full       = (r_count >= CW'(MAX_POINTS));
    assign cur        = r_job.edges[r_sel];
    assign key        = {cur.lo, cur.hi};
    assign lo_in      = (32'(cur.lo) < 32'(MAX_POINTS));
    assign hi_in      = (32'(cur.hi) < 32'(MAX_POINTS));
    assign v_pt       = hi_in ? r_pt_rd : '0;
    assign new_idx    = IDX_W'(r_count);
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_sweeping = (r_state == B_SWEEP);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;
    assign o_norm_req = '{start: r_start, x: r_sx, y: r_sy, z: r_sz};

    // Memory port steering
    always_comb begin
        pt_we   = 1'b0;
        pt_wa   = PW'(r_count);
        pt_wd   = {i_norm_rsp.x, i_norm_rsp.y, i_norm_rsp.z};
        pt_re   = 1'b0;
        pt_ra   = PW'(cur.lo);
        edge_we = 1'b0;
        edge_wa = r_slot;
        edge_wd = '{valid: 1'b1, key: key, idx: new_idx};
        edge_re = (r_state == B_PROBE_RD);
        unique case (r_state)
            B_SWEEP: begin
                edge_we = 1'b1;
                edge_wa = r_sweep;
                edge_wd = '0;
            end
            B_IDLE: begin
                pt_we = o_pop && (i_job.op == OP_LOAD) && !full;
                pt_wd = {i_job.x, i_job.y, i_job.z};
            end
            B_RD_U: begin
                pt_re = 1'b1;
            end
            B_RD_V: begin
                pt_re = 1'b1;
                pt_ra = PW'(cur.hi);
            end
            B_STORE: begin
                pt_we   = out_free;
                edge_we = out_free;
            end
            default: begin
                pt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            m_pt[pt_wa] <= pt_wd;
        end
        if (pt_re) begin
            r_pt_rd <= m_pt[pt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_edge[edge_wa] <= edge_wd;
        end
        if (edge_re) begin
            r_edge_rd <= m_edge[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_SWEEP;
            r_sweep     <= '0;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == SW'(EDGE_SLOTS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        unique case (i_job.op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_sweep <= '0;
                                r_state <= B_SWEEP;
                            end
                            OP_LOAD: begin
                                if (full) begin
                                    r_state <= B_OVF;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_TRI: begin
                                r_sel    <= '0;
                                r_slot   <= home_of(i_job.edges[0]);
                                r_probes <= '0;
                                r_state  <= B_PROBE_RD;
                            end
                            default: begin
                                r_state <= B_IDLE;
                            end
                        endcase
                    end
                end
                B_PROBE_RD: begin
                    r_state <= B_PROBE_CHK;
                end
                B_PROBE_CHK: begin
                    if (!r_edge_rd.valid) begin
                        r_state <= full ? B_OVF : B_RD_U;
                    end else if (r_edge_rd.key == key) begin
                        r_mid[r_sel] <= r_edge_rd.idx;
                        if (r_sel == 2'd2) begin
                            r_child <= '0;
                            r_state <= B_CHILD;
                        end else begin
                            r_sel    <= r_sel + 1'b1;
                            r_slot   <= home_of(r_job.edges[r_sel + 1'b1]);
                            r_probes <= '0;
                            r_state  <= B_PROBE_RD;
                        end
                    end else if (r_probes == PC_W'(EDGE_SLOTS - 1)) begin
                        r_state <= B_OVF;
                    end else begin
                        r_probes <= r_probes + 1'b1;
                        r_slot   <= (r_slot == SW'(EDGE_SLOTS - 1)) ? '0 : r_slot + 1'b1;
                        r_state  <= B_PROBE_RD;
                    end
                end
                B_RD_U: begin
                    r_state <= B_RD_V;
                end
                B_RD_V: begin
                    r_u_pt  <= lo_in ? r_pt_rd : '0;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_sx <= SUM_W'($signed(r_u_pt[3*COORD_W-1:2*COORD_W]))
                          + SUM_W'($signed(v_pt[3*COORD_W-1:2*COORD_W]));
                    r_sy <= SUM_W'($signed(r_u_pt[2*COORD_W-1:COORD_W]))
                          + SUM_W'($signed(v_pt[2*COORD_W-1:COORD_W]));
                    r_sz <= SUM_W'($signed(r_u_pt[COORD_W-1:0]))
                          + SUM_W'($signed(v_pt[COORD_W-1:0]));
                    r_start <= 1'b1;
                    r_state <= B_NORM;
                end
                B_NORM: begin
                    if (i_norm_rsp.done) begin
                        r_state <= B_STORE;
                    end
                end
                B_STORE: begin
                    if (out_free) begin
                        r_out        <= mk_mid(new_idx, i_norm_rsp.x, i_norm_rsp.y,
                                               i_norm_rsp.z);
                        r_out_valid  <= 1'b1;
                        r_count      <= r_count + 1'b1;
                        r_mid[r_sel] <= new_idx;
                        if (r_sel == 2'd2) begin
                            r_child <= '0;
                            r_state <= B_CHILD;
                        end else begin
                            r_sel    <= r_sel + 1'b1;
                            r_slot   <= home_of(r_job.edges[r_sel + 1'b1]);
                            r_probes <= '0;
                            r_state  <= B_PROBE_RD;
                        end
                    end
                end
                B_CHILD: begin
                    if (out_free) begin
                        case (r_child)
                            2'd0:    r_out <= mk_tri(r_job.a, r_mid[0], r_mid[1], 1'b0);
                            2'd1:    r_out <= mk_tri(r_mid[0], r_job.b, r_mid[2], 1'b0);
                            2'd2:    r_out <= mk_tri(r_mid[1], r_mid[2], r_job.c, 1'b0);
                            default: r_out <= mk_tri(r_mid[0], r_mid[2], r_mid[1], 1'b1);
                        endcase
                        r_out_valid <= 1'b1;
                        r_child     <= r_child + 1'b1;
                        if (r_child == 2'd3) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                B_OVF: begin
                    if (out_free) begin
                        r_out       <= mk_ovf();
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/triangle_midpoint_subdivider.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider
// One pass of geodesic sphere subdivision over a point store and edge table.
// ----------------------------------------------------------------------------
// Timing: a front end takes one beat per cycle, when not stalled, into a
// two-entry job queue; a single back end works one job at a time. After
// reset and on every clear command the back end sweeps all EDGE_SLOTS slots
// of the edge table (8192 by default), one slot per cycle, and the input
// stalls while it does. A load is done as the back end takes it from the
// queue. Each edge of a triangle probes table slots, each with a read state
// and then a compare state; a new edge also reads its two end points, sums
// them and runs the normalizer, which squares three axes and then finds each
// output bit by a candidate and test step, 15 bits per axis. Four child beats
// close the triangle, one per cycle when the output is not stalled. Results
// leave through a single output register.
module triangle_midpoint_subdivider #(
    parameter int MAX_POINTS = 4096,
    parameter int EDGE_SLOTS = 8192
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic signed [tms_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tms_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tms_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tms_pkg::IDX_W-1:0]          i_vertex_a,
    input  logic [tms_pkg::IDX_W-1:0]          i_vertex_b,
    input  logic [tms_pkg::IDX_W-1:0]          i_vertex_c,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_kind,
    output logic [tms_pkg::IDX_W-1:0]          o_new_index,
    output logic signed [tms_pkg::COORD_W-1:0] o_out_x,
    output logic signed [tms_pkg::COORD_W-1:0] o_out_y,
    output logic signed [tms_pkg::COORD_W-1:0] o_out_z,
    output logic [tms_pkg::IDX_W-1:0]          o_tri_a,
    output logic [tms_pkg::IDX_W-1:0]          o_tri_b,
    output logic [tms_pkg::IDX_W-1:0]          o_tri_c,
    output logic                               o_overflow,
    output logic                               o_last
);
    import tms_pkg::*;

    `include "triangle_midpoint_subdivider_macros.svh"

    logic      w_push, w_pop, w_empty, w_full, w_sweeping;
    t_job      w_job_in, w_job_out;
    t_norm_req w_norm_req;
    t_norm_rsp w_norm_rsp;
    t_result   w_res;

    // Decode and hash; hold input while the table sweep runs.
    tms_front #(
        .EDGE_SLOTS(EDGE_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_coord_z  (i_coord_z),
        .i_vertex_a (i_vertex_a),
        .i_vertex_b (i_vertex_b),
        .i_vertex_c (i_vertex_c),
        .i_hold     (w_sweeping),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    tms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Execute jobs against the point store and edge table.
    tms_back #(
        .MAX_POINTS(MAX_POINTS),
        .EDGE_SLOTS(EDGE_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job_out),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_sweeping (w_sweeping),
        .o_norm_req (w_norm_req),
        .i_norm_rsp (w_norm_rsp),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_res      (w_res)
    );

    tms_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_norm_req),
        .o_rsp   (w_norm_rsp)
    );

    assign o_kind      = w_res.kind;
    assign o_new_index = w_res.new_index;
    assign o_out_x     = w_res.x;
    assign o_out_y     = w_res.y;
    assign o_out_z     = w_res.z;
    assign o_tri_a     = w_res.tri_a;
    assign o_tri_b     = w_res.tri_b;
    assign o_tri_c     = w_res.tri_c;
    assign o_overflow  = w_res.overflow;
    assign o_last      = w_res.last;

    `TMS_ASSERT_NOW(a_sweep_stalls, i_clk, i_rst_n, w_sweeping, o_stall, "input open during sweep")
    `TMS_ASSERT_NOW(a_ovf_last, i_clk, i_rst_n, o_valid && o_overflow, o_last, "overflow beat not last")
    `TMS_ASSERT_NOW(a_tri_clean, i_clk, i_rst_n, o_valid && (o_kind == KIND_TRI), !o_overflow, "child beat flagged overflow")
    `TMS_ASSERT_NEXT(a_norm_latency, i_clk, i_rst_n, w_norm_req.start, !w_norm_rsp.done, "normalizer done too early")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider testbench
// Drives clear, load and subdivide beats through a queue-fed driver, predicts
// every midpoint, overflow and child triangle beat with an own model of the
// point store and edge table, and checks each output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tms_pkg::*;

    localparam int MAX_POINTS  = 4096;
    localparam int IDLE_LIMIT  = 40000;  // clear sweep plus a long hold-off
    localparam int HOLD_CYCLES = 12000;
    localparam int DRAIN_WAIT  = 600;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] x, y, z;
        logic [11:0]        a, b, c;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic r_valid = 1'b0;
    logic r_stall = 1'b0;
    logic [1:0] r_cmd = CMD_CLEAR;
    logic signed [15:0] r_x = '0, r_y = '0, r_z = '0;
    logic [11:0] r_a = '0, r_b = '0, r_c = '0;

    logic o_stall, o_valid, o_kind, o_overflow, o_last;
    logic [11:0] o_new_index, o_tri_a, o_tri_b, o_tri_c;
    logic signed [15:0] o_out_x, o_out_y, o_out_z;

    always #1 i_clk = ~i_clk;

    triangle_midpoint_subdivider u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_valid), .o_stall(o_stall),
        .i_cmd(r_cmd), .i_coord_x(r_x), .i_coord_y(r_y), .i_coord_z(r_z),
        .i_vertex_a(r_a), .i_vertex_b(r_b), .i_vertex_c(r_c),
        .o_valid(o_valid), .i_stall(r_stall), .o_kind(o_kind),
        .o_new_index(o_new_index), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_z(o_out_z), .o_tri_a(o_tri_a), .o_tri_b(o_tri_b),
        .o_tri_c(o_tri_c), .o_overflow(o_overflow), .o_last(o_last)
    );

    // Own copy of the mesh state
    logic signed [15:0] store_x [MAX_POINTS];
    logic signed [15:0] store_y [MAX_POINTS];
    logic signed [15:0] store_z [MAX_POINTS];
    int unsigned        point_cnt = 0;
    int                 edge_index [int];   // sorted key lo:hi -> point index

    t_beat   pending_q [$];
    t_result mesh_q [$];      // expected output beats, oldest first
    t_result step_q [$];      // beats of the step being predicted
    int      fail_cnt = 0;
    int      in_beats = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;     // stretch with no idling on either side
    bit      hold_armed = 1'b0;

    // round(|v| * 2^14 / sqrt(s)), halves away from zero, sign restored
    function automatic logic signed [15:0] unit_axis(int v, longint unsigned s);
        longint unsigned mag, rhs, t;
        int lo, hi, mid;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        rhs = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = longint'(2 * mid - 1);
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (v < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic t_result blank_beat();
        t_result r;
        r = '0;
        return r;
    endfunction

    // Look up one edge, make its midpoint if new; returns 0 on overflow.
    function automatic bit edge_midpoint(logic [11:0] u, logic [11:0] v,
                                         output logic [11:0] idx);
        logic [11:0] lo, hi;
        int key, sx, sy, sz;
        longint unsigned s;
        t_result r;
        lo = (u < v) ? u : v;
        hi = (u < v) ? v : u;
        key = int'({lo, hi});
        r = blank_beat();
        idx = '0;
        if (edge_index.exists(key)) begin
            idx = 12'(edge_index[key]);
            return 1'b1;
        end
        if (point_cnt >= MAX_POINTS) begin
            r.overflow = 1'b1;
            step_q.push_back(r);
            return 1'b0;
        end
        sx = int'(store_x[u]) + int'(store_x[v]);
        sy = int'(store_y[u]) + int'(store_y[v]);
        sz = int'(store_z[u]) + int'(store_z[v]);
        s = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
        if (s != 0) begin
            r.x = unit_axis(sx, s);
            r.y = unit_axis(sy, s);
            r.z = unit_axis(sz, s);
        end
        idx = 12'(point_cnt);
        store_x[point_cnt] = r.x;
        store_y[point_cnt] = r.y;
        store_z[point_cnt] = r.z;
        point_cnt++;
        edge_index[key] = idx;
        r.kind = KIND_MID;
        r.new_index = idx;
        step_q.push_back(r);
        return 1'b1;
    endfunction

    function automatic t_result child(logic [11:0] a, logic [11:0] b, logic [11:0] c);
        t_result r;
        r = blank_beat();
        r.kind = KIND_TRI;
        r.tri_a = a;
        r.tri_b = b;
        r.tri_c = c;
        return r;
    endfunction

    // Advance the mesh model by one accepted beat and queue its results.
    function automatic void mesh_step(t_beat bt);
        logic [11:0] ab, ac, bc;
        t_result r;
        bit ok;
        step_q.delete();
        case (bt.cmd)
            CMD_CLEAR: begin
                point_cnt = 0;
                edge_index.delete();
            end
            CMD_LOAD: begin
                if (point_cnt >= MAX_POINTS) begin
                    r = blank_beat();
                    r.overflow = 1'b1;
                    step_q.push_back(r);
                end else begin
                    store_x[point_cnt] = bt.x;
                    store_y[point_cnt] = bt.y;
                    store_z[point_cnt] = bt.z;
                    point_cnt++;
                end
            end
            CMD_TRI: begin
                ok = edge_midpoint(bt.a, bt.b, ab);
                if (ok) ok = edge_midpoint(bt.a, bt.c, ac);
                if (ok) ok = edge_midpoint(bt.b, bt.c, bc);
                if (ok) begin
                    step_q.push_back(child(bt.a, ab, ac));
                    step_q.push_back(child(ab, bt.b, bc));
                    step_q.push_back(child(ac, bc, bt.c));
                    step_q.push_back(child(ab, bc, ac));
                end
            end
            default: ;  // unused code: no effect
        endcase
        if (step_q.size() != 0) begin
            r = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
        end
        foreach (step_q[i]) mesh_q.push_back(step_q[i]);
    endfunction

    // Driver: hold a stalled beat, else advance to the next pending one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !o_stall) begin
                mesh_step('{r_cmd, r_x, r_y, r_z, r_a, r_b, r_c});
                in_beats++;
            end
            if (!r_valid || !o_stall) begin
                if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
                    t_beat bt;
                    bt = pending_q.pop_front();
                    r_valid <= 1'b1;
                    r_cmd <= bt.cmd;
                    r_x <= bt.x;
                    r_y <= bt.y;
                    r_z <= bt.z;
                    r_a <= bt.a;
                    r_b <= bt.b;
                    r_c <= bt.c;
                end else begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output beat, drive stall, run the watchdog.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall <= 1'b0;
        end else begin
            if (o_valid && !r_stall) begin
                if (mesh_q.size() == 0) begin
                    $error("unexpected output beat kind=%0d", o_kind);
                    fail_cnt++;
                end else begin
                    t_result e;
                    e = mesh_q.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, o_kind); fail_cnt++;
                    end
                    if (o_new_index !== e.new_index) begin
                        $error("new_index exp %0d got %0d", e.new_index, o_new_index);
                        fail_cnt++;
                    end
                    if (o_out_x !== e.x) begin
                        $error("out_x exp %0d got %0d", e.x, o_out_x); fail_cnt++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y exp %0d got %0d", e.y, o_out_y); fail_cnt++;
                    end
                    if (o_out_z !== e.z) begin
                        $error("out_z exp %0d got %0d", e.z, o_out_z); fail_cnt++;
                    end
                    if (o_tri_a !== e.tri_a) begin
                        $error("tri_a exp %0d got %0d", e.tri_a, o_tri_a); fail_cnt++;
                    end
                    if (o_tri_b !== e.tri_b) begin
                        $error("tri_b exp %0d got %0d", e.tri_b, o_tri_b); fail_cnt++;
                    end
                    if (o_tri_c !== e.tri_c) begin
                        $error("tri_c exp %0d got %0d", e.tri_c, o_tri_c); fail_cnt++;
                    end
                    if (o_overflow !== e.overflow) begin
                        $error("overflow exp %0d got %0d", e.overflow, o_overflow);
                        fail_cnt++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last); fail_cnt++;
                    end
                end
            end
            // one long hold-off while the driver keeps offering beats
            if (!hold_armed && in_beats >= 300) begin
                hold_armed = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) hold_left--;
            r_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 23);

            if ((r_valid && !o_stall) || (o_valid && !r_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic void add_load(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] z);
        pending_q.push_back('{CMD_LOAD, x, y, z, 12'd0, 12'd0, 12'd0});
    endfunction

    function automatic void add_tri(logic [11:0] a, logic [11:0] b, logic [11:0] c);
        pending_q.push_back('{CMD_TRI, 16'($urandom()), 16'($urandom()),
                              16'($urandom()), a, b, c});
    endfunction

    function automatic void add_cmd(logic [1:0] cmd);
        pending_q.push_back('{cmd, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                              12'($urandom()), 12'($urandom()), 12'($urandom())});
    endfunction

    initial begin
        int n, t, made;
        logic [11:0] a, b, c;

        // Directed: zero points, coordinate extremes, degenerate and repeated edges
        add_load(16'sd0, 16'sd0, 16'sd0);
        add_load(16'sd0, 16'sd0, 16'sd0);
        add_load(16'sd32767, 16'sd32767, 16'sd32767);
        add_load(16'sd32767, 16'sd32767, 16'sd32767);
        add_load(-16'sd32768, -16'sd32768, -16'sd32768);
        add_load(-16'sd32768, -16'sd32768, -16'sd32768);
        add_load(16'sd16384, 16'sd0, -16'sd1);
        add_load(16'sd0, -16'sd16384, 16'sd1);
        add_tri(12'd0, 12'd1, 12'd2);   // zero-sum edge
        add_tri(12'd2, 12'd3, 12'd4);
        add_tri(12'd4, 12'd5, 12'd6);
        add_tri(12'd7, 12'd7, 12'd7);   // all corners equal
        add_tri(12'd2, 12'd1, 12'd0);   // edges already known, reversed order
        add_cmd(2'd3);                  // unused code
        add_tri(12'd6, 12'd7, 12'd0);

        // Random passes: clear, a few loads, then triangles on loaded corners
        made = 0;
        while (made < 440) begin
            add_cmd(CMD_CLEAR);
            n = $urandom_range(3, 16);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0)
                    add_load($urandom_range(1) ? 16'sd32767 : -16'sd32768,
                             16'($urandom()), $urandom_range(1) ? 16'sd0 : -16'sd1);
                else
                    add_load(16'($urandom()), 16'($urandom()), 16'($urandom()));
            end
            t = $urandom_range(5, 30);
            a = 12'd0; b = 12'd1; c = 12'd2;
            for (int i = 0; i < t; i++) begin
                if ($urandom_range(9) == 0) add_cmd(2'd3);
                if ($urandom_range(9) != 0) begin
                    a = 12'($urandom_range(n - 1));
                    b = 12'($urandom_range(n - 1));
                    c = 12'($urandom_range(n - 1));
                end
                add_tri(a, b, c);
            end
            made += n + t + 1;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || r_valid) begin
            @(posedge i_clk);
            calm = (in_beats >= 150 && in_beats < 250);
        end
        calm = 1'b0;
        while (mesh_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_cnt == 0 && mesh_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
